// ----- rtl/rmq_pkg.sv -----
// Shared constants and the pipeline item type for the rotation matrix to quaternion unit.
// No dependencies.
`default_nettype none
package rmq_pkg;
	localparam int FRAC_BITS = 16;
	localparam int DW        = 18;                 // width of one matrix or quaternion field
	localparam int MW        = DW + 1;             // width of a numerator magnitude
	localparam int RW        = 19;                 // width of the root 2*sqrt(t)
	localparam int VW        = 37;                 // width of t << (FRAC_BITS + 2)
	localparam int DVW       = 36;                 // width of the rounded dividend
	localparam int QW        = 17;                 // quotient bits kept before saturation
	localparam int SQ_STAGES = RW;                 // one root bit per stage
	localparam int DV_STAGES = QW + 1;             // overflow test plus one quotient bit per stage
	localparam int NST       = 1 + SQ_STAGES + DV_STAGES;

	localparam logic signed [DW-1:0] ONE_FX = DW'(1 << FRAC_BITS);

	typedef enum logic [1:0] {
		BR_TRACE = 2'd0,
		BR_X     = 2'd1,
		BR_Y     = 2'd2,
		BR_Z     = 2'd3
	} branch_t;

	typedef struct packed {
		logic [1:0]                br;
		logic                      ident;
		logic [RW-1:0]             root;
		logic [VW-1:0]             rem;
		logic [2:0]                neg;
		logic [2:0][MW-1:0]        mag;
		logic [2:0][DVW-1:0]       drem;
		logic [2:0][QW-1:0]        quo;
		logic [2:0]                ovf;
	} item_t;
endpackage
`default_nettype wire

// ----- rtl/rotation_matrix_to_quaternion_unit.sv -----
// Rotation matrix to unit quaternion, Shepperd branch-on-largest method, fully pipelined.
// Depends on rmq_pkg.
//
// Usage:
//   Input beats on s_tvalid/s_tready/s_tdata carry the nine matrix elements in Q2.16.
//   Output beats on m_tvalid/m_tready/m_tdata carry qw, qx, qy, qz (Q2.16, saturated to
//   +/-1.0); m_tuser carries the branch taken (0 trace, 1 x, 2 y, 3 z largest).
//   An accepted input beat reaches its output beat through one decode stage, 19 square root
//   stages (one root bit each), 18 divider stages (overflow test, then one quotient bit each
//   for three dividers in parallel) and the output register. Throughput is one beat per
//   cycle when the output side does not stall.
//   Each stage holds its own valid bit and advances whenever the stage after it is empty
//   or advancing, so bubbles collapse under a stall and input keeps flowing while a
//   finished beat waits at the output. A stall never drops or repeats a beat.
//   Reset clears all valid bits; the block is then ready at once.
`default_nettype none
module rotation_matrix_to_quaternion_unit (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         s_tvalid,
	output logic              s_tready,
	// m00, m01, m02, m10, m11, m12, m20, m21, m22 (18 bits each), zero pad
	input  wire logic [167:0] s_tdata,
	output logic              m_tvalid,
	input  wire logic         m_tready,
	// qw, qx, qy, qz (18 bits each)
	output logic [71:0]       m_tdata,
	// branch_taken (2 bits)
	output logic [1:0]        m_tuser
);
	import rmq_pkg::*;

	item_t             pl_s [NST];
	logic [NST-1:0]    vld_s;
	logic [NST:0]      en;
	item_t             nxt [NST];
	logic              out_v_q;
	logic [DW-1:0]     qw_q, qx_q, qy_q, qz_q;
	logic [1:0]        br_q;

	// enable chain: a stage loads when it is empty or its successor loads
	always_comb begin
		en[NST] = !out_v_q || m_tready;
		for (int i = NST - 1; i >= 0; i--) begin
			en[i] = !vld_s[i] || en[i+1];
		end
	end
	assign s_tready = en[0];

	// decode stage
	logic signed [20:0] a [9];
	logic signed [20:0] trace, t, n0, n1, n2;
	logic [1:0]         br_d;
	always_comb begin
		for (int i = 0; i < 9; i++) begin
			a[i] = 21'(signed'(s_tdata[i*DW +: DW]));
		end
		trace = a[0] + a[4] + a[8];
		if (!trace[20]) begin
			br_d = BR_TRACE;
			t  = trace + 21'(ONE_FX);
			n0 = a[7] - a[5]; n1 = a[2] - a[6]; n2 = a[3] - a[1];
		end else if (a[0] > a[4] && a[0] > a[8]) begin
			br_d = BR_X;
			t  = 21'(ONE_FX) + a[0] - a[4] - a[8];
			n0 = a[7] - a[5]; n1 = a[1] + a[3]; n2 = a[6] + a[2];
		end else if (a[4] > a[8]) begin
			br_d = BR_Y;
			t  = 21'(ONE_FX) + a[4] - a[8] - a[0];
			n0 = a[2] - a[6]; n1 = a[1] + a[3]; n2 = a[5] + a[7];
		end else begin
			br_d = BR_Z;
			t  = 21'(ONE_FX) + a[8] - a[0] - a[4];
			n0 = a[3] - a[1]; n1 = a[6] + a[2]; n2 = a[5] + a[7];
		end
		nxt[0]       = '0;
		nxt[0].br    = br_d;
		nxt[0].ident = (s_tdata[0 +: DW] == ONE_FX) && (s_tdata[4*DW +: DW] == ONE_FX)
			&& (s_tdata[8*DW +: DW] == ONE_FX);
		nxt[0].rem   = (t[20] || t == 21'sd0) ? '0 : {t[RW-1:0], (FRAC_BITS + 2)'(0)};
		nxt[0].neg   = {n2[20], n1[20], n0[20]};
		nxt[0].mag[0] = n0[20] ? MW'(-n0) : MW'(n0);
		nxt[0].mag[1] = n1[20] ? MW'(-n1) : MW'(n1);
		nxt[0].mag[2] = n2[20] ? MW'(-n2) : MW'(n2);
	end

	// square root stages: root bit b = RW-1-k
	for (genvar k = 0; k < SQ_STAGES; k++) begin : g_sqrt
		localparam int B = RW - 1 - k;
		logic [VW:0] trial;
		always_comb begin
			nxt[k+1] = pl_s[k];
			trial = ({(VW + 1 - RW)'(0), pl_s[k].root} << (B + 1)) + ((VW + 1)'(1) << (2 * B));
			if ({1'b0, pl_s[k].rem} >= trial) begin
				nxt[k+1].rem     = pl_s[k].rem - trial[VW-1:0];
				nxt[k+1].root[B] = 1'b1;
			end
		end
	end

	// divider stages: first tests overflow, the rest produce quotient bit b = QW-1-(j-1)
	for (genvar j = 0; j < DV_STAGES; j++) begin : g_div
		localparam int SI = 1 + SQ_STAGES + j;
		if (j == 0) begin : g_ovf
			always_comb begin
				nxt[SI] = pl_s[SI-1];
				for (int c = 0; c < 3; c++) begin
					nxt[SI].drem[c] = {1'b0, pl_s[SI-1].mag[c], FRAC_BITS'(0)}
						+ DVW'(pl_s[SI-1].root >> 1);
					nxt[SI].ovf[c]  = nxt[SI].drem[c] >= {pl_s[SI-1].root, QW'(0)};
					nxt[SI].quo[c]  = '0;
				end
			end
		end else begin : g_bit
			localparam int B = QW - j;
			always_comb begin
				nxt[SI] = pl_s[SI-1];
				for (int c = 0; c < 3; c++) begin
					if (pl_s[SI-1].drem[c] >= ({(DVW - RW)'(0), pl_s[SI-1].root} << B)) begin
						nxt[SI].drem[c] = pl_s[SI-1].drem[c]
							- ({(DVW - RW)'(0), pl_s[SI-1].root} << B);
						nxt[SI].quo[c][B] = 1'b1;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (en[0]) begin
				vld_s[0] <= s_tvalid;
			end
			for (int i = 1; i < NST; i++) begin
				if (en[i]) begin
					vld_s[i] <= vld_s[i-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < NST; i++) begin
			if (en[i]) begin
				pl_s[i] <= nxt[i];
			end
		end
	end

	// final stage: saturate, round the root component, place components by branch; identity input gives (1, 0, 0, 0)
	item_t          fin;
	logic [DW-1:0]  sl [3];
	logic [DW-1:0]  rc;
	logic [RW:0]    rsum;
	logic [DW-1:0]  fw, fx, fy, fz;
	always_comb begin
		fin  = pl_s[NST-1];
		rsum = {1'b0, fin.root} + (RW + 1)'(2);
		rc   = (rsum[RW:2] > (RW - 1)'(ONE_FX)) ? ONE_FX : DW'(rsum[RW:2]);
		for (int c = 0; c < 3; c++) begin
			if (fin.root == '0 && fin.mag[c] == '0) begin
				sl[c] = '0;
			end else if (fin.ovf[c] || fin.quo[c] > QW'(ONE_FX)) begin
				sl[c] = fin.neg[c] ? DW'(-ONE_FX) : ONE_FX;
			end else begin
				sl[c] = fin.neg[c] ? DW'(-{1'b0, fin.quo[c]}) : DW'({1'b0, fin.quo[c]});
			end
		end
		case (fin.br)
			BR_TRACE: begin fw = rc;    fx = sl[0]; fy = sl[1]; fz = sl[2]; end
			BR_X:     begin fw = sl[0]; fx = rc;    fy = sl[1]; fz = sl[2]; end
			BR_Y:     begin fw = sl[0]; fx = sl[1]; fy = rc;    fz = sl[2]; end
			default:  begin fw = sl[0]; fx = sl[1]; fy = sl[2]; fz = rc;    end
		endcase
		if (fin.ident) begin
			fw = ONE_FX; fx = '0; fy = '0; fz = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en[NST]) begin
			out_v_q <= vld_s[NST-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NST]) begin
			qw_q <= fw;
			qx_q <= fx;
			qy_q <= fy;
			qz_q <= fz;
			br_q <= fin.ident ? BR_TRACE : fin.br;
		end
	end

	assign m_tvalid = out_v_q;
	assign m_tdata  = {qz_q, qy_q, qx_q, qw_q};
	assign m_tuser  = br_q;
endmodule
`default_nettype wire
